@@ sv/id_divider_list_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// id divider list parser assertion macros
// shared assertion forms for the parser modules
// ----------------------------------------------------------------------------
`ifndef ID_DIVIDER_LIST_PARSER_CORE_DEFINES_SVH
`define ID_DIVIDER_LIST_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define IDLP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("idlp check failed");

// next-cycle implication
`define IDLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("idlp check failed");

`endif

@@ sv/idlp_pkg.sv @@
// ----------------------------------------------------------------------------
// idlp_pkg
// types and constants shared by the list parser modules
// ----------------------------------------------------------------------------
package idlp_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_COMMA = 8'h2c;

	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [3:0]  DIGIT_BASE = 4'd10;
	localparam logic [31:0] SAT_VALUE  = 32'hffff_ffff;

	typedef enum logic [1:0] {
		CLS_DIGIT = 2'd0,
		CLS_SLASH = 2'd1,
		CLS_COMMA = 2'd2,
		CLS_OTHER = 2'd3
	} idlp_class_t;

	typedef struct packed {
		logic        is_end;
		idlp_class_t cls;
		logic [3:0]  digit;
	} idlp_token_t;

	typedef enum logic [4:0] {
		MODE_EXPECT_ID  = 5'b00001,
		MODE_IN_ID      = 5'b00010,
		MODE_EXPECT_DIV = 5'b00100,
		MODE_IN_DIV     = 5'b01000,
		MODE_ERROR      = 5'b10000
	} idlp_mode_t;

endpackage

@@ sv/idlp_front.sv @@
// ----------------------------------------------------------------------------
// idlp_front
// classifies each incoming character into a parser token
// ----------------------------------------------------------------------------
module idlp_front
	import idlp_pkg::*;
(
	input  logic [7:0]  char_code,
	input  logic        is_end,
	output idlp_token_t token
);

	idlp_class_t cls;

	always_comb begin
		if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
			cls = CLS_DIGIT;
		end else if (char_code == CHAR_SLASH) begin
			cls = CLS_SLASH;
		end else if (char_code == CHAR_COMMA) begin
			cls = CLS_COMMA;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign token.is_end = is_end;
	assign token.cls    = cls;
	assign token.digit  = 4'(char_code - CHAR_ZERO);

endmodule

@@ sv/idlp_queue.sv @@
// ----------------------------------------------------------------------------
// idlp_queue
// short token queue between the classifier and the parser
// ----------------------------------------------------------------------------
module idlp_queue
	import idlp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  idlp_token_t push_token,
	output logic        ready,
	input  logic        pop,
	output logic        head_valid,
	output idlp_token_t head_token
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	idlp_token_t   entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign ready      = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_token = entries_q[rd_ptr_q];
	assign do_push    = push && ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ sv/idlp_back.sv @@
// ----------------------------------------------------------------------------
// idlp_back
// parser state machine, decimal accumulator and result register
// ----------------------------------------------------------------------------
`include "id_divider_list_parser_core_defines.svh"

module idlp_back
	import idlp_pkg::*;
#(
	parameter int MAX_ENTRIES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  idlp_token_t tok,
	output logic        tok_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [31:0] out_id,
	output logic [31:0] out_div,
	output logic [6:0]  out_idx,
	output logic        out_last
);

	idlp_mode_t  mode_q;
	logic [31:0] acc_q;
	logic [31:0] held_q;
	logic [7:0]  count_q;
	logic        split_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_id_q;
	logic [31:0] out_div_q;
	logic [6:0]  out_idx_q;
	logic        out_last_q;

	idlp_mode_t  mode_d;
	logic [31:0] acc_d;
	logic [31:0] held_d;
	logic [7:0]  count_d;
	logic        split_d;

	logic        emit;
	logic [1:0]  emit_kind;
	logic [31:0] emit_id;
	logic [31:0] emit_div;
	logic [6:0]  emit_idx;
	logic        emit_last;
	logic        consume;

	logic        pending;
	logic [31:0] pair_id;
	logic [31:0] pair_div;
	logic [6:0]  pair_idx;
	logic [35:0] acc_wide;
	logic [31:0] acc_next;
	logic        out_free;
	logic        go;

	assign pending  = (mode_q == MODE_IN_ID) || (mode_q == MODE_EXPECT_DIV) ||
		(mode_q == MODE_IN_DIV);
	assign pair_id  = (mode_q == MODE_IN_ID) ? acc_q : held_q;
	assign pair_div = (mode_q == MODE_IN_DIV) ? acc_q : 32'd1;
	assign pair_idx = 7'(count_q - 8'd1);

	assign acc_wide = (36'(acc_q) << 3) + (36'(acc_q) << 1) + 36'(tok.digit);
	assign acc_next = (|acc_wide[35:32]) ? SAT_VALUE : acc_wide[31:0];

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		held_d    = held_q;
		count_d   = count_q;
		split_d   = split_q;
		emit      = 1'b0;
		emit_kind = KIND_ENTRY;
		emit_id   = pair_id;
		emit_div  = pair_div;
		emit_idx  = pair_idx;
		emit_last = 1'b0;
		consume   = 1'b1;
		if (tok.is_end) begin
			emit = 1'b1;
			if (pending && !split_q) begin
				split_d = 1'b1;
				consume = 1'b0;
			end else begin
				emit_kind = (mode_q == MODE_ERROR) ? KIND_ERROR : KIND_OK;
				emit_id   = '0;
				emit_div  = '0;
				emit_idx  = '0;
				emit_last = 1'b1;
				mode_d    = MODE_EXPECT_ID;
				acc_d     = '0;
				held_d    = '0;
				count_d   = '0;
				split_d   = 1'b0;
			end
		end else if (mode_q != MODE_ERROR) begin
			case (tok.cls)
				CLS_DIGIT: begin
					if (mode_q == MODE_EXPECT_ID) begin
						if (count_q >= 8'(MAX_ENTRIES)) begin
							mode_d = MODE_ERROR;
						end else begin
							acc_d   = 32'(tok.digit);
							count_d = count_q + 8'd1;
							mode_d  = MODE_IN_ID;
						end
					end else if (mode_q == MODE_EXPECT_DIV) begin
						acc_d  = 32'(tok.digit);
						mode_d = MODE_IN_DIV;
					end else begin
						acc_d = acc_next;
					end
				end
				CLS_SLASH: begin
					if (mode_q == MODE_IN_ID) begin
						held_d = acc_q;
						acc_d  = '0;
						mode_d = MODE_EXPECT_DIV;
					end else begin
						mode_d = MODE_ERROR;
					end
				end
				CLS_COMMA: begin
					if (mode_q == MODE_IN_ID || mode_q == MODE_IN_DIV) begin
						emit   = 1'b1;
						acc_d  = '0;
						mode_d = MODE_EXPECT_ID;
					end else begin
						mode_d = MODE_ERROR;
					end
				end
				default: begin
					mode_d = MODE_ERROR;
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign go       = tok_valid && (!emit || out_free);
	assign tok_pop  = go && consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_EXPECT_ID;
			acc_q       <= '0;
			held_q      <= '0;
			count_q     <= '0;
			split_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				mode_q  <= mode_d;
				acc_q   <= acc_d;
				held_q  <= held_d;
				count_q <= count_d;
				split_q <= split_d;
			end
			if (go && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_kind_q <= emit_kind;
			out_id_q   <= emit_id;
			out_div_q  <= emit_div;
			out_idx_q  <= emit_idx;
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_id    = out_id_q;
	assign out_div   = out_div_q;
	assign out_idx   = out_idx_q;
	assign out_last  = out_last_q;

	`IDLP_ASSERT_SAME(a_status_zero, clk, arst_n, out_valid_q && out_last_q,
		out_kind_q != KIND_ENTRY && out_id_q == '0 && out_div_q == '0)
	`IDLP_ASSERT_NEXT(a_end_clears, clk, arst_n, go && tok.is_end && consume,
		mode_q == MODE_EXPECT_ID && count_q == '0 && !split_q)
	`IDLP_ASSERT_SAME(a_split_pending, clk, arst_n, split_q, pending && tok_valid && tok.is_end)

endmodule

@@ sv/id_divider_list_parser_core.sv @@
// ----------------------------------------------------------------------------
// id_divider_list_parser_core
// parses "id[/divider],..." character streams into (id, divider) entries
// ----------------------------------------------------------------------------
// a character passes through the token queue and then the parser step into the output register
// throughput: one character per cycle, unless the output stalls or an end marker is held
// an end marker with a pending entry is held while the parser emits the entry, then the status
// reset: asynchronous, queue empty, parser expecting an id, no result valid
module id_divider_list_parser_core
	import idlp_pkg::*;
#(
	parameter int MAX_ENTRIES = 128,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // char_code
	input  logic        s_axis_tlast,  // action (end of list)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // message_id, rate_divider, entry_index, pad
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast   // last
);

	idlp_token_t front_token;
	idlp_token_t head_token;
	logic        head_valid;
	logic        head_pop;
	logic [31:0] out_id;
	logic [31:0] out_div;
	logic [6:0]  out_idx;

	idlp_front u_front (
		.char_code (s_axis_tdata),
		.is_end    (s_axis_tlast),
		.token     (front_token)
	);

	idlp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_axis_tvalid),
		.push_token (front_token),
		.ready      (s_axis_tready),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_token (head_token)
	);

	idlp_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (head_valid),
		.tok       (head_token),
		.tok_pop   (head_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_id    (out_id),
		.out_div   (out_div),
		.out_idx   (out_idx),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_idx, out_div, out_id};

endmodule
